>>> hdl/assert_macros.svh
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define DD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define DD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dd_pkg.sv
package dd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned RANK_W  = 23;
    localparam int unsigned CUM_W   = 9;
    localparam int unsigned QUOT_W  = 8;
    localparam int unsigned REM_W   = 7;

    // y / 100 == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
        logic               include_end;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               bad_date;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_YEAR,
        ST_SUM,
        ST_DONE
    } t_state;

    // Which of the two dates the datapath is ranking.
    typedef enum logic {
        SEL_END,
        SEL_START
    } t_sel;

    typedef struct packed {
        logic load;
        t_sel sel;
        logic mul;
        logic year;
        logic sum;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // Days in all months before month m; months past December count the whole year.
    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] c;
        case (m)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd365;
        endcase
        return c;
    endfunction

    // Length of month m; zero for a month code outside January to December.
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

>>> hdl/dd_if.sv
interface dd_in_if;
    logic                           valid;
    logic                           ready;
    logic [dd_pkg::DAY_W-1:0]       start_day;
    logic [dd_pkg::MONTH_W-1:0]     start_month;
    logic [dd_pkg::YEAR_W-1:0]      start_year;
    logic [dd_pkg::DAY_W-1:0]       end_day;
    logic [dd_pkg::MONTH_W-1:0]     end_month;
    logic [dd_pkg::YEAR_W-1:0]      end_year;
    logic                           include_end;

    modport source (
        output valid, start_day, start_month, start_year,
               end_day, end_month, end_year, include_end,
        input  ready
    );
    modport sink (
        input  valid, start_day, start_month, start_year,
               end_day, end_month, end_year, include_end,
        output ready
    );
endinterface

interface dd_out_if;
    logic                           valid;
    logic                           ready;
    logic [dd_pkg::COUNT_W-1:0]     day_count;
    logic                           bad_date;

    modport source (output valid, day_count, bad_date, input ready);
    modport sink (input valid, day_count, bad_date, output ready);
endinterface

>>> hdl/dd_ctrl.sv
module dd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  dd_pkg::t_status  i_status,
    output logic             o_in_ready,
    output dd_pkg::t_cmd     o_cmd
);

    dd_pkg::t_state r_state, n_state;
    dd_pkg::t_sel   r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dd_pkg::ST_IDLE;
            r_sel   <= dd_pkg::SEL_END;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        case (r_state)
            dd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = dd_pkg::SEL_END;
                    n_state    = dd_pkg::ST_MUL;
                end
            end
            dd_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = dd_pkg::ST_YEAR;
            end
            dd_pkg::ST_YEAR: begin
                o_cmd.year = 1'b1;
                n_state    = dd_pkg::ST_SUM;
            end
            dd_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                if (r_sel == dd_pkg::SEL_END) begin
                    n_sel   = dd_pkg::SEL_START;
                    n_state = dd_pkg::ST_MUL;
                end else begin
                    n_state = dd_pkg::ST_DONE;
                end
            end
            dd_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = dd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/dd_datapath.sv
module dd_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dd_pkg::t_cmd     i_cmd,
    input  dd_pkg::t_item    i_item,
    input  logic             i_out_ready,
    output dd_pkg::t_status  o_status,
    output logic             o_out_valid,
    output dd_pkg::t_result  o_result
);

    localparam int unsigned PROD_W = dd_pkg::YEAR_W + 13;

    dd_pkg::t_item              r_item;
    logic [dd_pkg::QUOT_W-1:0]  r_q;
    logic [dd_pkg::RANK_W-1:0]  r_y365;
    logic [dd_pkg::RANK_W-1:0]  r_yr;
    logic                       r_leap;
    logic [dd_pkg::RANK_W-1:0]  r_rank_e;
    logic [dd_pkg::RANK_W-1:0]  r_rank_s;
    logic                       r_bad;
    logic                       r_out_valid;
    dd_pkg::t_result            r_result;

    logic [dd_pkg::YEAR_W-1:0]  y_sel;
    logic [dd_pkg::MONTH_W-1:0] m_sel;
    logic [dd_pkg::DAY_W-1:0]   d_sel;
    logic [PROD_W-1:0]          prod;
    logic [14:0]                q100;
    logic [dd_pkg::REM_W-1:0]   rem;
    logic [dd_pkg::YEAR_W-1:0]  pyr;
    logic [dd_pkg::QUOT_W-1:0]  p100;
    logic [dd_pkg::RANK_W-1:0]  yr;
    logic                       leap;
    logic [dd_pkg::DAY_W-1:0]   mlen;
    logic [dd_pkg::DAY_W-1:0]   prior_days;
    logic [dd_pkg::DAY_W-1:0]   dm1;
    logic [dd_pkg::RANK_W-1:0]  rank;
    logic                       bad;
    logic                       less;
    logic                       sd_zero;
    logic [dd_pkg::RANK_W:0]    count;
    logic [dd_pkg::COUNT_W-1:0] count_sat;

    always_comb begin
        sd_zero = (r_item.start_day == '0);
        if (i_cmd.sel == dd_pkg::SEL_START) begin
            y_sel = r_item.start_year;
            m_sel = r_item.start_month;
            d_sel = sd_zero ? dd_pkg::DAY_W'(1) : r_item.start_day;
        end else begin
            y_sel = r_item.end_year;
            m_sel = r_item.end_month;
            d_sel = r_item.end_day;
        end
    end

    // Year term: 365*y + (y-1)/4 - (y-1)/100 + (y-1)/400 + 1, or zero for year zero.
    always_comb begin
        prod = PROD_W'(y_sel) * PROD_W'(dd_pkg::RECIP_100);
        q100 = 15'(r_q) * 15'd100;
        rem  = dd_pkg::REM_W'(y_sel - q100[dd_pkg::YEAR_W-1:0]);
        if (rem != '0) begin
            leap = (y_sel[1:0] == 2'b00);
            p100 = r_q;
        end else begin
            leap = (r_q[1:0] == 2'b00);
            p100 = r_q - 8'd1;
        end
        pyr = y_sel - dd_pkg::YEAR_W'(1);
        if (y_sel == '0) begin
            yr = '0;
        end else begin
            yr = r_y365 + dd_pkg::RANK_W'(pyr[dd_pkg::YEAR_W-1:2])
               + dd_pkg::RANK_W'(p100[dd_pkg::QUOT_W-1:2]) + dd_pkg::RANK_W'(1)
               - dd_pkg::RANK_W'(p100);
        end
    end

    // Month and day terms, and the start-date validity check.
    always_comb begin
        mlen = dd_pkg::month_len(r_leap, m_sel);
        dm1  = d_sel - dd_pkg::DAY_W'(1);
        if (d_sel == '0) begin
            prior_days = '0;
        end else if (dm1 > mlen) begin
            prior_days = mlen;
        end else begin
            prior_days = dm1;
        end
        rank = r_yr + dd_pkg::RANK_W'(dd_pkg::cum_days(m_sel))
             + dd_pkg::RANK_W'(r_leap && (m_sel >= dd_pkg::MONTH_W'(3)))
             + dd_pkg::RANK_W'(prior_days);
        bad  = (r_item.start_month == '0) || (r_item.start_month > dd_pkg::MONTH_W'(12))
            || (r_item.start_day > mlen);
    end

    always_comb begin
        less = {r_item.start_year, r_item.start_month, r_item.start_day}
             < {r_item.end_year, r_item.end_month, r_item.end_day};
        if (less) begin
            count = (dd_pkg::RANK_W+1)'(r_rank_e - r_rank_s)
                  + (dd_pkg::RANK_W+1)'(sd_zero)
                  + (dd_pkg::RANK_W+1)'(r_item.include_end);
        end else begin
            count = (dd_pkg::RANK_W+1)'(r_item.include_end);
        end
        if (r_bad) begin
            count_sat = '0;
        end else if (count > (dd_pkg::RANK_W+1)'(dd_pkg::COUNT_MAX)) begin
            count_sat = dd_pkg::COUNT_MAX;
        end else begin
            count_sat = count[dd_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.mul) begin
            r_q    <= prod[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
            r_y365 <= dd_pkg::RANK_W'(y_sel) * dd_pkg::RANK_W'(365);
        end
        if (i_cmd.year) begin
            r_yr   <= yr;
            r_leap <= leap;
        end
        if (i_cmd.sum) begin
            if (i_cmd.sel == dd_pkg::SEL_START) begin
                r_rank_s <= rank;
                r_bad    <= bad;
            end else begin
                r_rank_e <= rank;
            end
        end
        if (i_cmd.done) begin
            r_result.day_count <= count_sat;
            r_result.bad_date  <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_result;

endmodule

>>> hdl/date_difference_in_days.sv
// One transaction at a time: the datapath ranks the end date and then the start
// date through the same 3-step multiply, year and sum sequence, and a new input
// is taken only once the controller is back in idle.
// Reset: synchronous, active low; the controller returns to idle and the
// output register is emptied. Data registers are not reset.
module date_difference_in_days (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dd_in_if.sink    i_in,
    dd_out_if.source o_out
);

    // The block reduces each date to its rank, the number of valid dates that
    // lie before it counting from year zero. The day count is then the
    // difference of the two ranks, with a day added when the start sits on day
    // zero of its month, plus the include-end bit.
    //
    // The controller steps the datapath through three phases per date:
    //   multiply: y / 100 by reciprocal and 365 * y, both registered;
    //   year:     leap flag and the year term of the rank;
    //   sum:      month and day terms, giving the rank.
    // A final step forms the count, saturates it to 22 bits and loads the
    // output register. A new transaction is taken once the controller is idle,
    // even while a finished result is still waiting in the output register.

    dd_pkg::t_cmd    cmd;
    dd_pkg::t_status status;
    dd_pkg::t_item   item;
    dd_pkg::t_result result;
    logic            in_ready;

    assign item.start_day   = i_in.start_day;
    assign item.start_month = i_in.start_month;
    assign item.start_year  = i_in.start_year;
    assign item.end_day     = i_in.end_day;
    assign item.end_month   = i_in.end_month;
    assign item.end_year    = i_in.end_year;
    assign item.include_end = i_in.include_end;

    assign i_in.ready = in_ready;

    dd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    dd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (item),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_result    (result)
    );

    assign o_out.day_count = result.day_count;
    assign o_out.bad_date  = result.bad_date;

endmodule

>>> hdl/dd_checker.sv
`include "assert_macros.svh"

module dd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [dd_pkg::COUNT_W-1:0] i_day_count,
    input logic                       i_bad_date
);

    // A stalled result stays offered.
    `DD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // An invalid start date always comes with a zero count.
    `DD_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_bad_date, i_day_count == '0, "bad date with nonzero count")

    // One transaction at a time: the input closes right after an acceptance.
    `DD_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input accepted while busy")

    // A result cannot appear in the cycle right after an acceptance.
    `DD_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid, !i_out_valid, "result too early")

endmodule

bind date_difference_in_days dd_checker u_dd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_day_count (o_out.day_count),
    .i_bad_date  (o_out.bad_date)
);
